>>> design/assert_macros.svh
// assertion macros for the classifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on clk, quiet while rst_n is low
`define TLC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tlc assertion failed");

// checked on clk, also during reset
`define TLC_ASSERT_NRST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tlc assertion failed");

`else

`define TLC_ASSERT(lbl, clk, rst_n, prop)
`define TLC_ASSERT_NRST(lbl, clk, prop)

`endif

`endif

>>> design/tlc_pkg.sv
// types and constants of the terrain tile lod classifier
`default_nettype none

package tlc_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int TILES_W    = 19;
  localparam int MIP_W      = 5;
  localparam int OFS_W      = 16;
  localparam int CLASS_W    = 3;
  localparam int SWS_W      = 9;
  localparam int LOD_W      = 5;
  localparam int TS_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // resolution is square size times 1024
  localparam int RES_SHIFT = 10;
  localparam int RES_W     = SWS_W + RES_SHIFT;

  // distance to the square stays within 2^24 on each axis
  localparam int D_W  = 25;
  localparam int SQ_W = 2 * D_W;
  localparam int D2_W = SQ_W + 1;

  // highest lod step that the search looks at
  localparam int LOD_K_LIMIT = 30;

  // tile counts below this are dropped
  localparam int MIN_TILES = 4;

  // pipelined divider: quotient bits per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (RES_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_STAGES * DIV_BITS;

  // register reset values
  localparam logic [SWS_W-1:0]          SWS_RST       = SWS_W'(64);
  localparam logic [LOD_W-1:0]          MAX_LOD_RST   = LOD_W'(5);
  localparam logic [TS_W-1:0]           TILE_SIZE_RST = TS_W'(256);
  localparam logic signed [COORD_W-1:0] CAM_RST       = '0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SQUARE_WORLD_SIZE = 3'd0,
    REG_MAX_LOD           = 3'd1,
    REG_TILE_SIZE         = 3'd2,
    REG_CAMERA_X          = 3'd3,
    REG_CAMERA_Z          = 3'd4
  } cfg_reg_t;

  // change classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_UNCHANGED = 3'd0,
    CLS_CREATED   = 3'd1,
    CLS_GREW      = 3'd2,
    CLS_SHRANK    = 3'd3,
    CLS_DELETED   = 3'd4
  } change_class_t;

  // fields that ride along the pipeline untouched
  typedef struct packed {
    logic [TILES_W-1:0] prev_tiles;
    logic [MIP_W-1:0]   prev_mip;
    logic [OFS_W-1:0]   prev_offset_x;
    logic [OFS_W-1:0]   prev_offset_y;
  } pass_t;

endpackage

`default_nettype wire

>>> design/tlc_cfg_if.sv
// configuration write channel
`default_nettype none

interface tlc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tlc_pkg::CFG_IDX_W-1:0]    index;
  logic [tlc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/tlc_in_if.sv
// input channel carrying one terrain square
`default_nettype none

interface tlc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tlc_pkg::COORD_W-1:0] corner_x;
  logic signed [tlc_pkg::COORD_W-1:0] corner_z;
  logic [tlc_pkg::TILES_W-1:0]        prev_tiles;
  logic [tlc_pkg::MIP_W-1:0]          prev_mip;
  logic [tlc_pkg::OFS_W-1:0]          prev_offset_x;
  logic [tlc_pkg::OFS_W-1:0]          prev_offset_y;

  modport source (output valid, output corner_x, output corner_z, output prev_tiles,
                  output prev_mip, output prev_offset_x, output prev_offset_y,
                  input ready);
  modport sink   (input valid, input corner_x, input corner_z, input prev_tiles,
                  input prev_mip, input prev_offset_x, input prev_offset_y,
                  output ready);
endinterface

`default_nettype wire

>>> design/tlc_out_if.sv
// result channel carrying one classified square
`default_nettype none

interface tlc_out_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::TILES_W-1:0]   old_tile_count;
  logic [tlc_pkg::MIP_W-1:0]     old_mip;
  logic [tlc_pkg::OFS_W-1:0]     old_offset_x;
  logic [tlc_pkg::OFS_W-1:0]     old_offset_y;
  logic [tlc_pkg::TILES_W-1:0]   new_tile_count;
  logic [tlc_pkg::MIP_W-1:0]     new_mip;
  logic [tlc_pkg::CLASS_W-1:0]   change_class;

  modport source (output valid, output old_tile_count, output old_mip, output old_offset_x,
                  output old_offset_y, output new_tile_count, output new_mip,
                  output change_class, input ready);
  modport sink   (input valid, input old_tile_count, input old_mip, input old_offset_x,
                  input old_offset_y, input new_tile_count, input new_mip,
                  input change_class, output ready);
endinterface

`default_nettype wire

>>> design/terrain_tile_lod_classifier.sv
// top level of the terrain tile lod classifier, a ten stage pipeline
// stages: offset, square, lod, resolution, five divider stages of four quotient bits, classify
// throughput: one word per cycle; the whole pipe holds while the output stalls
// reset: synchronous rst_n clears all valid bits and loads register defaults
`default_nettype none
`include "assert_macros.svh"

module terrain_tile_lod_classifier #(
  parameter int FRAC_BITS     = 8,
  parameter int SWITCH_METERS = 10,
  parameter int FAR_METERS    = 300
) (
  input  logic       clk,
  input  logic       rst_n,
  tlc_cfg_if.sink    cfg_ch,
  tlc_in_if.sink     in_ch,
  tlc_out_if.source  out_ch
);

  localparam int HI_W =
    ((tlc_pkg::SWS_W + FRAC_BITS) > tlc_pkg::COORD_W ?
     (tlc_pkg::SWS_W + FRAC_BITS) : tlc_pkg::COORD_W) + 2;
  localparam logic [63:0] FAR_FX = 64'(FAR_METERS) << FRAC_BITS;
  localparam logic [63:0] FAR_SQ = FAR_FX * FAR_FX;
  localparam int NS = tlc_pkg::DIV_STAGES;

  // squared switch distance for lod step k, in fixed point
  function automatic logic [63:0] thr_sq(int k);
    logic [63:0] m;
    m = (64'(SWITCH_METERS) << k) << FRAC_BITS;
    return m * m;
  endfunction

  // distance from camera to the square on one axis
  function automatic logic [tlc_pkg::D_W-1:0] axis_dist(
    logic signed [HI_W-1:0] cam,
    logic signed [HI_W-1:0] lo,
    logic signed [HI_W-1:0] span
  );
    logic signed [HI_W-1:0] hi;
    logic signed [HI_W-1:0] diff;
    hi = lo + span;
    if (cam < lo) begin
      diff = lo - cam;
    end else if (cam > hi) begin
      diff = cam - hi;
    end else begin
      diff = '0;
    end
    return diff[tlc_pkg::D_W-1:0];
  endfunction

  // configuration registers
  logic [tlc_pkg::SWS_W-1:0]          sws_r;
  logic [tlc_pkg::LOD_W-1:0]          max_lod_r;
  logic [tlc_pkg::TS_W-1:0]           tile_size_r;
  logic signed [tlc_pkg::COORD_W-1:0] cam_x_r;
  logic signed [tlc_pkg::COORD_W-1:0] cam_z_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sws_r       <= tlc_pkg::SWS_RST;
      max_lod_r   <= tlc_pkg::MAX_LOD_RST;
      tile_size_r <= tlc_pkg::TILE_SIZE_RST;
      cam_x_r     <= tlc_pkg::CAM_RST;
      cam_z_r     <= tlc_pkg::CAM_RST;
    end else if (cfg_ch.valid) begin
      unique case (tlc_pkg::cfg_reg_t'(cfg_ch.index))
        tlc_pkg::REG_SQUARE_WORLD_SIZE: sws_r <= cfg_ch.data[tlc_pkg::SWS_W-1:0];
        tlc_pkg::REG_MAX_LOD:           max_lod_r <= cfg_ch.data[tlc_pkg::LOD_W-1:0];
        tlc_pkg::REG_TILE_SIZE:         tile_size_r <= cfg_ch.data[tlc_pkg::TS_W-1:0];
        tlc_pkg::REG_CAMERA_X:          cam_x_r <= cfg_ch.data[tlc_pkg::COORD_W-1:0];
        tlc_pkg::REG_CAMERA_Z:          cam_z_r <= cfg_ch.data[tlc_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances when the output register is free or drained
  logic pipe_en;
  logic out_v_r;

  assign pipe_en     = !out_v_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  // stage 1: per axis offset to the clamped point
  logic signed [HI_W-1:0]     span;
  logic [tlc_pkg::D_W-1:0]    dx_nxt;
  logic [tlc_pkg::D_W-1:0]    dz_nxt;
  tlc_pkg::pass_t             in_pass;

  assign span   = HI_W'(sws_r) << FRAC_BITS;
  assign dx_nxt = axis_dist(HI_W'(cam_x_r), HI_W'(in_ch.corner_x), span);
  assign dz_nxt = axis_dist(HI_W'(cam_z_r), HI_W'(in_ch.corner_z), span);
  assign in_pass = '{prev_tiles:    in_ch.prev_tiles,
                     prev_mip:      in_ch.prev_mip,
                     prev_offset_x: in_ch.prev_offset_x,
                     prev_offset_y: in_ch.prev_offset_y};

  logic                     s1_v_r;
  logic [tlc_pkg::D_W-1:0]  s1_dx_r;
  logic [tlc_pkg::D_W-1:0]  s1_dz_r;
  tlc_pkg::pass_t           s1_pass_r;

  // stage 2: squares
  logic                      s2_v_r;
  logic [tlc_pkg::SQ_W-1:0]  s2_sqx_r;
  logic [tlc_pkg::SQ_W-1:0]  s2_sqz_r;
  tlc_pkg::pass_t            s2_pass_r;

  // stage 3: squared distance against the switch thresholds
  logic [tlc_pkg::D2_W-1:0]      d2;
  logic [63:0]                   d2_ext;
  logic                          near_nxt;
  logic [tlc_pkg::LOD_K_LIMIT:1] ge;
  logic [tlc_pkg::LOD_W-1:0]     lod_nxt;

  assign d2       = tlc_pkg::D2_W'(s2_sqx_r) + tlc_pkg::D2_W'(s2_sqz_r);
  assign d2_ext   = 64'(d2);
  assign near_nxt = (d2_ext <= FAR_SQ);

  for (genvar k = 1; k <= tlc_pkg::LOD_K_LIMIT; k++) begin : g_thr
    localparam logic [63:0] THR  = thr_sq(k);
    localparam bit          STEP = ((64'(SWITCH_METERS) << k) <= 64'(FAR_METERS));
    assign ge[k] = STEP && (d2_ext >= THR);
  end

  // thresholds rise with k, so the highest hit is the lod
  always_comb begin
    lod_nxt = '0;
    for (int k = 1; k <= tlc_pkg::LOD_K_LIMIT; k++) begin
      if (ge[k]) begin
        lod_nxt = tlc_pkg::LOD_W'(k);
      end
    end
  end

  logic                       s3_v_r;
  logic                       s3_near_r;
  logic [tlc_pkg::LOD_W-1:0]  s3_lod_r;
  tlc_pkg::pass_t             s3_pass_r;

  // stage 4: capped lod and resolution
  logic [tlc_pkg::LOD_W-1:0]  lod_cap;
  logic [tlc_pkg::RES_W-1:0]  res_nxt;

  assign lod_cap = (s3_lod_r > max_lod_r) ? max_lod_r : s3_lod_r;
  assign res_nxt = s3_near_r ?
                   ({sws_r, {tlc_pkg::RES_SHIFT{1'b0}}} >> lod_cap) : '0;

  logic                       s4_v_r;
  logic [tlc_pkg::RES_W-1:0]  s4_res_r;
  tlc_pkg::pass_t             s4_pass_r;

  // divider stages: restoring division by tile_size
  logic                        div_v_r    [NS];
  logic [tlc_pkg::DIV_W-1:0]   div_num_r  [NS];
  logic [tlc_pkg::TS_W-1:0]    div_rem_r  [NS];
  logic [tlc_pkg::DIV_W-1:0]   div_quo_r  [NS];
  tlc_pkg::pass_t              div_pass_r [NS];

  logic                        div_v_src    [NS];
  logic [tlc_pkg::DIV_W-1:0]   div_num_src  [NS];
  logic [tlc_pkg::TS_W-1:0]    div_rem_src  [NS];
  logic [tlc_pkg::DIV_W-1:0]   div_quo_src  [NS];
  tlc_pkg::pass_t              div_pass_src [NS];

  logic [tlc_pkg::DIV_W-1:0]   div_num_nxt  [NS];
  logic [tlc_pkg::TS_W-1:0]    div_rem_nxt  [NS];
  logic [tlc_pkg::DIV_W-1:0]   div_quo_nxt  [NS];

  assign div_v_src[0]    = s4_v_r;
  assign div_num_src[0]  = tlc_pkg::DIV_W'(s4_res_r);
  assign div_rem_src[0]  = '0;
  assign div_quo_src[0]  = '0;
  assign div_pass_src[0] = s4_pass_r;

  for (genvar s = 1; s < NS; s++) begin : g_div_src
    assign div_v_src[s]    = div_v_r[s-1];
    assign div_num_src[s]  = div_num_r[s-1];
    assign div_rem_src[s]  = div_rem_r[s-1];
    assign div_quo_src[s]  = div_quo_r[s-1];
    assign div_pass_src[s] = div_pass_r[s-1];
  end

  always_comb begin
    logic [tlc_pkg::TS_W:0]    trial;
    logic [tlc_pkg::DIV_W-1:0] num;
    logic [tlc_pkg::TS_W-1:0]  rem;
    logic [tlc_pkg::DIV_W-1:0] quo;
    logic                      qbit;
    for (int s = 0; s < NS; s++) begin
      num = div_num_src[s];
      rem = div_rem_src[s];
      quo = div_quo_src[s];
      for (int b = 0; b < tlc_pkg::DIV_BITS; b++) begin
        trial = {rem, num[tlc_pkg::DIV_W-1]};
        num   = num << 1;
        qbit  = (trial >= {1'b0, tile_size_r});
        if (qbit) begin
          trial = trial - {1'b0, tile_size_r};
        end
        rem = trial[tlc_pkg::TS_W-1:0];
        quo = {quo[tlc_pkg::DIV_W-2:0], qbit};
      end
      div_num_nxt[s] = num;
      div_rem_nxt[s] = rem;
      div_quo_nxt[s] = quo;
    end
  end

  // last stage: tile count, mip and change class
  logic [tlc_pkg::RES_W-1:0]    quot;
  logic [tlc_pkg::TILES_W-1:0]  tiles_nxt;
  logic [tlc_pkg::MIP_W-1:0]    mip_nxt;
  tlc_pkg::change_class_t       cls_nxt;
  tlc_pkg::pass_t               fin_pass;

  assign quot     = div_quo_r[NS-1][tlc_pkg::RES_W-1:0];
  assign fin_pass = div_pass_r[NS-1];
  assign tiles_nxt =
    (tile_size_r == '0 || quot < tlc_pkg::RES_W'(tlc_pkg::MIN_TILES)) ?
    '0 : tlc_pkg::TILES_W'(quot);

  always_comb begin
    mip_nxt = '0;
    for (int b = 0; b < tlc_pkg::TILES_W; b++) begin
      if (tiles_nxt[b]) begin
        mip_nxt = tlc_pkg::MIP_W'(b);
      end
    end
  end

  always_comb begin
    cls_nxt = tlc_pkg::CLS_UNCHANGED;
    if (tiles_nxt != '0) begin
      if (fin_pass.prev_tiles == '0) begin
        cls_nxt = tlc_pkg::CLS_CREATED;
      end else if (tiles_nxt > fin_pass.prev_tiles) begin
        cls_nxt = tlc_pkg::CLS_GREW;
      end else if (tiles_nxt < fin_pass.prev_tiles) begin
        cls_nxt = tlc_pkg::CLS_SHRANK;
      end
    end else if (fin_pass.prev_tiles != '0) begin
      cls_nxt = tlc_pkg::CLS_DELETED;
    end
  end

  logic [tlc_pkg::TILES_W-1:0]  out_tiles_r;
  logic [tlc_pkg::MIP_W-1:0]    out_mip_r;
  tlc_pkg::change_class_t       out_cls_r;
  tlc_pkg::pass_t               out_pass_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      for (int s = 0; s < NS; s++) begin
        div_v_r[s] <= 1'b0;
      end
      out_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r  <= in_ch.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      for (int s = 0; s < NS; s++) begin
        div_v_r[s] <= div_v_src[s];
      end
      out_v_r <= div_v_r[NS-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_dx_r   <= dx_nxt;
      s1_dz_r   <= dz_nxt;
      s1_pass_r <= in_pass;
      s2_sqx_r  <= tlc_pkg::SQ_W'(s1_dx_r) * tlc_pkg::SQ_W'(s1_dx_r);
      s2_sqz_r  <= tlc_pkg::SQ_W'(s1_dz_r) * tlc_pkg::SQ_W'(s1_dz_r);
      s2_pass_r <= s1_pass_r;
      s3_near_r <= near_nxt;
      s3_lod_r  <= lod_nxt;
      s3_pass_r <= s2_pass_r;
      s4_res_r  <= res_nxt;
      s4_pass_r <= s3_pass_r;
      for (int s = 0; s < NS; s++) begin
        div_num_r[s]  <= div_num_nxt[s];
        div_rem_r[s]  <= div_rem_nxt[s];
        div_quo_r[s]  <= div_quo_nxt[s];
        div_pass_r[s] <= div_pass_src[s];
      end
      out_tiles_r <= tiles_nxt;
      out_mip_r   <= mip_nxt;
      out_cls_r   <= cls_nxt;
      out_pass_r  <= fin_pass;
    end
  end

  // result word
  assign out_ch.valid          = out_v_r;
  assign out_ch.old_tile_count = out_pass_r.prev_tiles;
  assign out_ch.old_mip        = out_pass_r.prev_mip;
  assign out_ch.old_offset_x   = out_pass_r.prev_offset_x;
  assign out_ch.old_offset_y   = out_pass_r.prev_offset_y;
  assign out_ch.new_tile_count = out_tiles_r;
  assign out_ch.new_mip        = out_mip_r;
  assign out_ch.change_class   = out_cls_r;

  // checks
  `TLC_ASSERT_NRST(a_reset_clears_out, clk, !rst_n |=> !out_ch.valid)
  `TLC_ASSERT(a_stall_holds_pipe, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(s1_v_r) && $stable(s4_v_r) && $stable(div_v_r[NS-1]))
  `TLC_ASSERT(a_mip_matches_count, clk, rst_n, out_ch.valid && out_ch.new_tile_count != '0 |-> (out_ch.new_tile_count >> out_ch.new_mip) == tlc_pkg::TILES_W'(1))
  `TLC_ASSERT(a_created_from_empty, clk, rst_n, out_ch.valid && out_ch.change_class == tlc_pkg::CLS_CREATED |-> out_ch.old_tile_count == '0 && out_ch.new_tile_count >= tlc_pkg::TILES_W'(tlc_pkg::MIN_TILES))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the terrain tile lod classifier: directed edges, random settings, backpressure
`timescale 1ns / 100ps

module tb;

  localparam int FRAC_BITS     = 8;
  localparam int SWITCH_METERS = 10;
  localparam int FAR_METERS    = 300;
  localparam int ONE_METER     = 1 << FRAC_BITS;
  localparam int PIPE_LATENCY  = 10;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 120;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_SQUARES = 150;
  localparam int REPORT_LIMIT  = 40;

  // one terrain square as offered on the input channel
  typedef struct packed {
    logic [tlc_pkg::COORD_W-1:0] corner_x;
    logic [tlc_pkg::COORD_W-1:0] corner_z;
    logic [tlc_pkg::TILES_W-1:0] prev_tiles;
    logic [tlc_pkg::MIP_W-1:0]   prev_mip;
    logic [tlc_pkg::OFS_W-1:0]   prev_offset_x;
    logic [tlc_pkg::OFS_W-1:0]   prev_offset_y;
  } square_t;

  // expected classification of one square
  typedef struct packed {
    logic [tlc_pkg::TILES_W-1:0] old_tiles;
    logic [tlc_pkg::MIP_W-1:0]   old_mip;
    logic [tlc_pkg::OFS_W-1:0]   old_ofs_x;
    logic [tlc_pkg::OFS_W-1:0]   old_ofs_y;
    logic [tlc_pkg::TILES_W-1:0] new_tiles;
    logic [tlc_pkg::MIP_W-1:0]   new_mip;
    tlc_pkg::change_class_t      cls;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  tlc_cfg_if cfg_ch ();
  tlc_in_if  in_ch ();
  tlc_out_if out_ch ();

  terrain_tile_lod_classifier #(
    .FRAC_BITS    (FRAC_BITS),
    .SWITCH_METERS(SWITCH_METERS),
    .FAR_METERS   (FAR_METERS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // register copies used by the predictor
  logic [tlc_pkg::SWS_W-1:0]          cur_sws       = tlc_pkg::SWS_RST;
  logic [tlc_pkg::LOD_W-1:0]          cur_max_lod   = tlc_pkg::MAX_LOD_RST;
  logic [tlc_pkg::TS_W-1:0]           cur_tile_size = tlc_pkg::TILE_SIZE_RST;
  logic signed [tlc_pkg::COORD_W-1:0] cur_cam_x     = tlc_pkg::CAM_RST;
  logic signed [tlc_pkg::COORD_W-1:0] cur_cam_z     = tlc_pkg::CAM_RST;

  verdict_t pending_verdicts[$];
  int       mismatches     = 0;
  int       squares_sent   = 0;
  int       verdicts_seen  = 0;
  int       settings_used  = 1;
  int       class_seen [5] = '{0, 0, 0, 0, 0};
  int       burst_left     = 0;
  bit       steady_input   = 1'b0;
  int       hold_requests  = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // distance from camera to the square on one axis, clamped into [lo, lo + span]
  function automatic longint axis_gap(longint cam, longint lo, longint span);
    longint p;
    p = cam;
    if (p < lo) p = lo;
    if (p > lo + span) p = lo + span;
    return (p > cam) ? p - cam : cam - p;
  endfunction

  function automatic longint meters_sq(longint m);
    return (m << FRAC_BITS) * (m << FRAC_BITS);
  endfunction

  // new tile count of a square under the current settings
  function automatic logic [tlc_pkg::TILES_W-1:0] lod_tile_count(
    logic signed [tlc_pkg::COORD_W-1:0] cx,
    logic signed [tlc_pkg::COORD_W-1:0] cz);
    longint span, dx, dz, d2, res, tiles;
    int     lod;
    span  = longint'(cur_sws) << FRAC_BITS;
    dx    = axis_gap(longint'(cur_cam_x), longint'(cx), span);
    dz    = axis_gap(longint'(cur_cam_z), longint'(cz), span);
    d2    = dx * dx + dz * dz;
    res   = 0;
    tiles = 0;
    if (d2 <= meters_sq(FAR_METERS)) begin
      // largest k with d >= switch distance * 2^k, never past the far limit
      lod = 0;
      for (int k = 1; k < 31 && (longint'(SWITCH_METERS) << k) <= FAR_METERS &&
           d2 >= meters_sq(longint'(SWITCH_METERS) << k); k++)
        lod = k;
      if (lod > int'(cur_max_lod)) lod = int'(cur_max_lod);
      res = (longint'(cur_sws) * 1024) >> lod;
    end
    if (cur_tile_size != '0) tiles = res / longint'(cur_tile_size);
    if (tiles < tlc_pkg::MIN_TILES) tiles = 0;
    return tlc_pkg::TILES_W'(tiles);
  endfunction

  // full expected result for one square
  function automatic verdict_t classify_square(square_t sq);
    verdict_t                    v;
    logic [tlc_pkg::TILES_W-1:0] t;
    logic [tlc_pkg::TILES_W-1:0] rest;
    int                          mip;
    t   = lod_tile_count(sq.corner_x, sq.corner_z);
    mip = 0;
    rest = t;
    while (rest > 1) begin
      rest = rest >> 1;
      mip++;
    end
    v.old_tiles = sq.prev_tiles;
    v.old_mip   = sq.prev_mip;
    v.old_ofs_x = sq.prev_offset_x;
    v.old_ofs_y = sq.prev_offset_y;
    v.new_tiles = t;
    v.new_mip   = tlc_pkg::MIP_W'(mip);
    if (t >= tlc_pkg::MIN_TILES) begin
      if (sq.prev_tiles == '0) v.cls = tlc_pkg::CLS_CREATED;
      else if (t > sq.prev_tiles) v.cls = tlc_pkg::CLS_GREW;
      else if (t < sq.prev_tiles) v.cls = tlc_pkg::CLS_SHRANK;
      else v.cls = tlc_pkg::CLS_UNCHANGED;
    end else if (sq.prev_tiles != '0) begin
      v.cls = tlc_pkg::CLS_DELETED;
    end else begin
      v.cls = tlc_pkg::CLS_UNCHANGED;
    end
    return v;
  endfunction

  function automatic square_t make_square(longint cx, longint cz, int unsigned prev,
                                          int unsigned mip, int unsigned ox, int unsigned oy);
    square_t sq;
    sq.corner_x      = tlc_pkg::COORD_W'(cx);
    sq.corner_z      = tlc_pkg::COORD_W'(cz);
    sq.prev_tiles    = tlc_pkg::TILES_W'(prev);
    sq.prev_mip      = tlc_pkg::MIP_W'(mip);
    sq.prev_offset_x = tlc_pkg::OFS_W'(ox);
    sq.prev_offset_y = tlc_pkg::OFS_W'(oy);
    return sq;
  endfunction

  // random square, mostly within a few hundred meters of the camera
  function automatic square_t random_square();
    square_t                     sq;
    longint                      span, reach, step;
    logic [tlc_pkg::TILES_W-1:0] t;
    int                          pick, j;
    span  = longint'(cur_sws) << FRAC_BITS;
    reach = longint'(340) << FRAC_BITS;
    pick  = $urandom_range(0, 9);
    if (pick < 2) begin
      sq.corner_x = tlc_pkg::COORD_W'($urandom);
      sq.corner_z = tlc_pkg::COORD_W'($urandom);
    end else if (pick < 4) begin
      // x distance on or next to a lod step or the far limit, camera inside on z
      j    = $urandom_range(0, 4);
      step = (j == 4) ? longint'(FAR_METERS) : (longint'(2 * SWITCH_METERS) << j);
      step = (step << FRAC_BITS) + longint'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 0)
        sq.corner_x = tlc_pkg::COORD_W'(longint'(cur_cam_x) + step);
      else
        sq.corner_x = tlc_pkg::COORD_W'(longint'(cur_cam_x) - span - step);
      sq.corner_z = tlc_pkg::COORD_W'(longint'(cur_cam_z) -
                                      longint'($urandom_range(0, int'(span))));
    end else begin
      sq.corner_x = tlc_pkg::COORD_W'(longint'(cur_cam_x) + reach -
                                      longint'($urandom_range(0, int'(span + 2 * reach))));
      sq.corner_z = tlc_pkg::COORD_W'(longint'(cur_cam_z) + reach -
                                      longint'($urandom_range(0, int'(span + 2 * reach))));
    end
    // previous count near the new one so every change class shows up
    t = lod_tile_count(sq.corner_x, sq.corner_z);
    case ($urandom_range(0, 7))
      0, 1:    sq.prev_tiles = '0;
      2, 3:    sq.prev_tiles = t;
      4:       sq.prev_tiles = t + 1'b1;
      5:       sq.prev_tiles = t - 1'b1;
      default: sq.prev_tiles = tlc_pkg::TILES_W'($urandom) >>
                               $urandom_range(0, tlc_pkg::TILES_W - 1);
    endcase
    sq.prev_mip      = tlc_pkg::MIP_W'($urandom);
    sq.prev_offset_x = tlc_pkg::OFS_W'($urandom);
    sq.prev_offset_y = tlc_pkg::OFS_W'($urandom);
    return sq;
  endfunction

  // offer one square, wait for the handshake, then idle at the end of a burst unless input is steady
  task automatic send_square(square_t sq);
    in_ch.valid         <= 1'b1;
    in_ch.corner_x      <= sq.corner_x;
    in_ch.corner_z      <= sq.corner_z;
    in_ch.prev_tiles    <= sq.prev_tiles;
    in_ch.prev_mip      <= sq.prev_mip;
    in_ch.prev_offset_x <= sq.prev_offset_x;
    in_ch.prev_offset_y <= sq.prev_offset_y;
    do @(posedge clk); while (!in_ch.ready);
    pending_verdicts.push_back(classify_square(sq));
    squares_sent++;
    if (!steady_input) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      end
    end
  endtask

  task automatic release_input();
    if (in_ch.valid) in_ch.valid <= 1'b0;
  endtask

  // wait for every expected word, then let the pipe settle
  task automatic drain_results();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // one register write; the caller lowers valid after the last one
  task automatic write_reg(tlc_pkg::cfg_reg_t idx, logic [tlc_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      tlc_pkg::REG_SQUARE_WORLD_SIZE: cur_sws       = value[tlc_pkg::SWS_W-1:0];
      tlc_pkg::REG_MAX_LOD:           cur_max_lod   = value[tlc_pkg::LOD_W-1:0];
      tlc_pkg::REG_TILE_SIZE:         cur_tile_size = value[tlc_pkg::TS_W-1:0];
      tlc_pkg::REG_CAMERA_X:          cur_cam_x     = value[tlc_pkg::COORD_W-1:0];
      tlc_pkg::REG_CAMERA_Z:          cur_cam_z     = value[tlc_pkg::COORD_W-1:0];
      default: ;
    endcase
  endtask

  // reprogram all registers with the pipe empty
  task automatic program_config(logic [tlc_pkg::SWS_W-1:0] sws,
                                logic [tlc_pkg::LOD_W-1:0] mlod,
                                logic [tlc_pkg::TS_W-1:0] ts,
                                logic signed [tlc_pkg::COORD_W-1:0] cx,
                                logic signed [tlc_pkg::COORD_W-1:0] cz);
    drain_results();
    write_reg(tlc_pkg::REG_SQUARE_WORLD_SIZE, tlc_pkg::CFG_DATA_W'(sws));
    write_reg(tlc_pkg::REG_MAX_LOD, tlc_pkg::CFG_DATA_W'(mlod));
    write_reg(tlc_pkg::REG_TILE_SIZE, tlc_pkg::CFG_DATA_W'(ts));
    write_reg(tlc_pkg::REG_CAMERA_X, tlc_pkg::CFG_DATA_W'(cx));
    write_reg(tlc_pkg::REG_CAMERA_Z, tlc_pkg::CFG_DATA_W'(cz));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // reset settings: camera at origin, 64 m squares, lod cap 5, 256 texel tiles
  task automatic test_default_edges();
    // camera inside the square: unchanged, created, grew, shrank and the field extremes
    send_square(make_square(-ONE_METER, -ONE_METER, 256, 31, 'hFFFF, 'hFFFF));
    send_square(make_square(-ONE_METER, -ONE_METER, 0, 0, 0, 0));
    send_square(make_square(-ONE_METER, -ONE_METER, 100, 7, 1, 2));
    send_square(make_square(-ONE_METER, -ONE_METER, 'h7FFFF, 18, 3, 4));
    // exactly at the far limit still counts as near, one step past is far
    send_square(make_square(FAR_METERS * ONE_METER, -ONE_METER, 0, 1, 5, 6));
    send_square(make_square(FAR_METERS * ONE_METER + 1, -ONE_METER, 16, 2, 7, 8));
    send_square(make_square(FAR_METERS * ONE_METER + 1, -ONE_METER, 0, 3, 9, 10));
    send_square(make_square(-64 * ONE_METER - FAR_METERS * ONE_METER, -ONE_METER, 16, 4,
                            11, 12));
    // lod steps on each boundary, and just below the first and the last one
    send_square(make_square(20 * ONE_METER - 1, -ONE_METER, 256, 8, 13, 14));
    send_square(make_square(20 * ONE_METER, -ONE_METER, 256, 8, 15, 16));
    send_square(make_square(40 * ONE_METER, -ONE_METER, 64, 6, 17, 18));
    send_square(make_square(80 * ONE_METER, -ONE_METER, 31, 5, 19, 20));
    send_square(make_square(160 * ONE_METER - 1, -ONE_METER, 32, 5, 21, 22));
    send_square(make_square(160 * ONE_METER, -ONE_METER, 32, 5, 23, 24));
    // diagonal across the far limit
    send_square(make_square(54305, 54305, 0, 0, 25, 26));
    send_square(make_square(54306, 54306, 0, 0, 27, 28));
    // corner coordinate extremes
    send_square(make_square(-8388608, 8388607, 5, 2, 29, 30));
    send_square(make_square(8388607, -8388608, 0, 0, 31, 32));
    release_input();
  endtask

  // zero tile size, collapsed square, oversized square, lod cap, camera extremes
  task automatic test_special_settings();
    program_config(64, 5, 0, 0, 0);
    send_square(make_square(-ONE_METER, -ONE_METER, 3, 1, 0, 0));
    release_input();
    program_config(0, 5, 1, 0, 0);
    send_square(make_square(0, 0, 0, 0, 0, 0));
    release_input();
    program_config(511, 31, 1, 0, 0);
    send_square(make_square(-ONE_METER, -ONE_METER, 0, 0, 0, 0));
    send_square(make_square(FAR_METERS * ONE_METER, -ONE_METER, 40000, 0, 0, 0));
    release_input();
    // a cap of zero keeps full resolution far away; tile count lands on the minimum
    program_config(256, 0, 65536, 0, 0);
    send_square(make_square(200 * ONE_METER, -ONE_METER, 0, 0, 0, 0));
    release_input();
    program_config(256, 0, 65537, -8388608, 8388607);
    send_square(make_square(-8388608, 8388607, 4, 2, 0, 0));
    release_input();
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    program_config(128, 31, 64, 0, 0);
    hold_requests++;
    steady_input = 1'b1;
    repeat (40) send_square(random_square());
    steady_input = 1'b0;
    release_input();
  endtask

  // random squares over a series of settings, extremes first
  task automatic test_random_settings();
    logic [tlc_pkg::SWS_W-1:0]          sws;
    logic [tlc_pkg::LOD_W-1:0]          mlod;
    logic [tlc_pkg::TS_W-1:0]           ts;
    logic signed [tlc_pkg::COORD_W-1:0] cx, cz;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sws  = tlc_pkg::SWS_W'($urandom_range(1, 256));
      mlod = tlc_pkg::LOD_W'($urandom_range(0, 31));
      if ($urandom_range(0, 1) == 0) ts = tlc_pkg::TS_W'(1 << $urandom_range(0, 16));
      else ts = tlc_pkg::TS_W'($urandom_range(1, int'(sws) * 256));
      cx = tlc_pkg::COORD_W'($urandom);
      cz = tlc_pkg::COORD_W'($urandom);
      case (phase)
        0: begin
          sws  = tlc_pkg::SWS_W'(1);
          mlod = tlc_pkg::LOD_W'(0);
          ts   = tlc_pkg::TS_W'(1);
        end
        1: begin
          sws  = tlc_pkg::SWS_W'(256);
          mlod = tlc_pkg::LOD_W'(31);
          ts   = tlc_pkg::TS_W'(65536);
        end
        2: begin
          sws  = tlc_pkg::SWS_W'(511);
          mlod = tlc_pkg::LOD_W'(31);
          ts   = tlc_pkg::TS_W'(1);
          cx   = -24'sd8388608;
          cz   = -24'sd8388608;
        end
        3: begin
          sws = tlc_pkg::SWS_W'(0);
          cx  = 24'sd8388607;
          cz  = 24'sd8388607;
        end
        4: ts = tlc_pkg::TS_W'(0);
        5: ts = tlc_pkg::TS_W'(131071);
        default: ;
      endcase
      program_config(sws, mlod, ts, cx, cz);
      repeat (PHASE_SQUARES) send_square(random_square());
      release_input();
    end
  endtask

  // main sequence
  initial begin
    rst_n               <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= tlc_pkg::REG_SQUARE_WORLD_SIZE;
    cfg_ch.data         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.corner_x      <= '0;
    in_ch.corner_z      <= '0;
    in_ch.prev_tiles    <= '0;
    in_ch.prev_mip      <= '0;
    in_ch.prev_offset_x <= '0;
    in_ch.prev_offset_y <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_default_edges();
    test_special_settings();
    test_backpressure();
    test_random_settings();
    drain_results();
    $display("covered %0d squares, %0d results, %0d register settings",
             squares_sent, verdicts_seen, settings_used);
    $display("classes: unchanged %0d created %0d grew %0d shrank %0d deleted %0d",
             class_seen[int'(tlc_pkg::CLS_UNCHANGED)], class_seen[int'(tlc_pkg::CLS_CREATED)],
             class_seen[int'(tlc_pkg::CLS_GREW)], class_seen[int'(tlc_pkg::CLS_SHRANK)],
             class_seen[int'(tlc_pkg::CLS_DELETED)]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: changing stall patterns plus long hold-offs on request
  initial begin : result_sink
    int         mode, mode_left, hold_left, holds_served;
    logic [7:0] mask;
    out_ch.ready <= 1'b0;
    mode         = 0;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    mask         = 8'hFF;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
        mask      = 8'($urandom);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ch.ready <= mask[0];
            mask = {mask[0], mask[7:1]};
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected result word, expected none, actual tiles %0d", $time,
                 out_ch.new_tile_count);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("old_tile_count", want.old_tiles, out_ch.old_tile_count);
        check_field("old_mip", want.old_mip, out_ch.old_mip);
        check_field("old_offset_x", want.old_ofs_x, out_ch.old_offset_x);
        check_field("old_offset_y", want.old_ofs_y, out_ch.old_offset_y);
        check_field("new_tile_count", want.new_tiles, out_ch.new_tile_count);
        check_field("new_mip", want.new_mip, out_ch.new_mip);
        check_field("change_class", want.cls, out_ch.change_class);
        class_seen[int'(want.cls)]++;
        verdicts_seen++;
      end
    end
  end

  // watchdog: ends the run when no handshake happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready)))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t timeout: no handshake for %0d cycles, %0d results outstanding", $time,
             STALL_LIMIT, pending_verdicts.size());
    $display("status: fail");
    $finish;
  end

endmodule

>>> terrain_tile_lod_classifier.f
+incdir+design
design/tlc_pkg.sv
design/tlc_cfg_if.sv
design/tlc_in_if.sv
design/tlc_out_if.sv
design/terrain_tile_lod_classifier.sv
tb/sv/tb.sv
